>>> rtl/idm_pkg.sv
package idm_pkg;

  localparam int unsigned TYPE_W = 5;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned SLOT_W = 7;

  // result action codes
  localparam logic [2:0] ACT_CLEARED  = 3'd0;
  localparam logic [2:0] ACT_DROPPED  = 3'd1;
  localparam logic [2:0] ACT_PUSHED   = 3'd2;
  localparam logic [2:0] ACT_MATCHED  = 3'd3;
  localparam logic [2:0] ACT_CMT_ENT  = 3'd4;
  localparam logic [2:0] ACT_CMT_EXIT = 3'd5;
  localparam logic [2:0] ACT_OVERFLOW = 3'd6;

  // entry event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_EXIT  = 2'd2;

  localparam logic OP_LINE_START = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic [TYPE_W-1:0] token_type;
    logic              may_open;
    logic [POS_W-1:0]  line_end_pos;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] partner_slot;
    logic [POS_W-1:0]  exit_pos;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_COMMENT,
    KIND_TOKEN
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [TYPE_W-1:0] token_type;
    logic              may_open;
    logic [POS_W-1:0]  line_end_pos;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic              may_open;
    logic [1:0]        event_code;
  } entry_t;

endpackage

>>> rtl/idm_ram.sv
module idm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/idm_front.sv
module idm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  idm_pkg::in_word_t      in_word,
  input  logic [idm_pkg::TYPE_W-1:0] comment_code,
  input  logic                   pop,
  output logic                   busy,
  output logic                   head_valid,
  output idm_pkg::cmd_t          head
);

  idm_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  idm_pkg::cmd_t cls;

  // classify the word on the way in
  always_comb begin
    cls.token_type   = in_word.token_type;
    cls.may_open     = in_word.may_open;
    cls.line_end_pos = in_word.line_end_pos;
    if (in_word.opcode == idm_pkg::OP_LINE_START) begin
      cls.kind = idm_pkg::KIND_CLEAR;
    end else if (in_word.token_type == comment_code) begin
      cls.kind = idm_pkg::KIND_COMMENT;
    end else begin
      cls.kind = idm_pkg::KIND_TOKEN;
    end
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && head_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop && head_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> rtl/idm_back.sv
module idm_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  idm_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  output idm_pkg::out_word_t out_word
);

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMMENT2,
    ST_SCAN,
    ST_PUSHC,
    ST_ADV,
    ST_ADVCHK
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   lb_r, lb_nxt;
  logic               cc_r, cc_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  idm_pkg::cmd_t      cmd_r, cmd_nxt;
  logic               out_valid_r, out_valid_nxt;
  idm_pkg::out_word_t out_word_r, out_word_nxt;

  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  idm_pkg::entry_t    wdata, rdata;
  idm_pkg::cmd_t      tk;
  logic               full;

  idm_ram #(
    .WIDTH ($bits(idm_pkg::entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full = (count_r >= CNT_W'(STACK_DEPTH));
  assign tk   = (state_r == ST_IDLE) ? head : cmd_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lb_nxt        = lb_r;
    cc_nxt        = cc_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    we            = 1'b0;
    waddr         = count_r[ADDR_W-1:0];
    wdata         = '0;
    raddr         = lb_r[ADDR_W-1:0];
    pop           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          pop     = 1'b1;
          cmd_nxt = head;
          out_word_nxt.last = 1'b1;
          if (head.kind == idm_pkg::KIND_CLEAR) begin
            count_nxt     = '0;
            lb_nxt        = '0;
            cc_nxt        = 1'b0;
            out_valid_nxt = 1'b1;
            out_word_nxt.action = idm_pkg::ACT_CLEARED;
          end else if (cc_r) begin
            out_valid_nxt = 1'b1;
            out_word_nxt.action = idm_pkg::ACT_DROPPED;
          end else if (head.kind == idm_pkg::KIND_COMMENT) begin
            out_valid_nxt     = 1'b1;
            out_word_nxt.last = 1'b0;
            out_word_nxt.slot = idm_pkg::SLOT_W'(count_r);
            if (!full) begin
              we        = 1'b1;
              wdata     = '{etype: head.token_type, may_open: head.may_open,
                            event_code: idm_pkg::EV_ENTER};
              count_nxt = count_r + 1'b1;
              out_word_nxt.action = idm_pkg::ACT_CMT_ENT;
            end else begin
              out_word_nxt.action = idm_pkg::ACT_OVERFLOW;
            end
            state_nxt = ST_COMMENT2;
          end else if (count_r > lb_r) begin
            raddr     = ADDR_W'(count_r - 1'b1);
            idx_nxt   = ADDR_W'(count_r - 1'b1);
            state_nxt = ST_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            if (!head.may_open) begin
              out_word_nxt.action = idm_pkg::ACT_DROPPED;
            end else begin
              out_word_nxt.slot = idm_pkg::SLOT_W'(count_r);
              if (!full) begin
                we        = 1'b1;
                wdata     = '{etype: head.token_type, may_open: 1'b1,
                              event_code: idm_pkg::EV_NONE};
                count_nxt = count_r + 1'b1;
                out_word_nxt.action = idm_pkg::ACT_PUSHED;
              end else begin
                out_word_nxt.action = idm_pkg::ACT_OVERFLOW;
              end
            end
          end
        end
      end
      ST_COMMENT2: begin
        out_valid_nxt     = 1'b1;
        out_word_nxt.last = 1'b1;
        out_word_nxt.slot = idm_pkg::SLOT_W'(count_r);
        if (!full) begin
          we        = 1'b1;
          wdata     = '{etype: tk.token_type, may_open: 1'b0,
                        event_code: idm_pkg::EV_EXIT};
          count_nxt = count_r + 1'b1;
          out_word_nxt.action   = idm_pkg::ACT_CMT_EXIT;
          out_word_nxt.exit_pos = tk.line_end_pos;
        end else begin
          out_word_nxt.action = idm_pkg::ACT_OVERFLOW;
        end
        cc_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (rdata.etype == tk.token_type && rdata.may_open &&
            rdata.event_code == idm_pkg::EV_NONE) begin
          out_valid_nxt     = 1'b1;
          out_word_nxt.last = 1'b1;
          out_word_nxt.slot = idm_pkg::SLOT_W'(count_r);
          if (full) begin
            out_word_nxt.action = idm_pkg::ACT_OVERFLOW;
            state_nxt = ST_IDLE;
          end else begin
            // mark the opener now, push the closer next cycle
            we    = 1'b1;
            waddr = idx_r;
            wdata = '{etype: tk.token_type, may_open: 1'b1,
                      event_code: idm_pkg::EV_ENTER};
            out_word_nxt.action       = idm_pkg::ACT_MATCHED;
            out_word_nxt.partner_slot = idm_pkg::SLOT_W'(idx_r);
            state_nxt = ST_PUSHC;
          end
        end else if (rdata.etype > tk.token_type || CNT_W'(idx_r) <= lb_r) begin
          out_valid_nxt     = 1'b1;
          out_word_nxt.last = 1'b1;
          state_nxt         = ST_IDLE;
          if (!tk.may_open) begin
            out_word_nxt.action = idm_pkg::ACT_DROPPED;
          end else begin
            out_word_nxt.slot = idm_pkg::SLOT_W'(count_r);
            if (!full) begin
              we        = 1'b1;
              wdata     = '{etype: tk.token_type, may_open: 1'b1,
                            event_code: idm_pkg::EV_NONE};
              count_nxt = count_r + 1'b1;
              out_word_nxt.action = idm_pkg::ACT_PUSHED;
            end else begin
              out_word_nxt.action = idm_pkg::ACT_OVERFLOW;
            end
          end
        end else begin
          raddr   = idx_r - 1'b1;
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_PUSHC: begin
        we        = 1'b1;
        wdata     = '{etype: tk.token_type, may_open: tk.may_open,
                      event_code: idm_pkg::EV_EXIT};
        count_nxt = count_r + 1'b1;
        state_nxt = (CNT_W'(idx_r) == lb_r) ? ST_ADV : ST_IDLE;
      end
      ST_ADV: begin
        if (lb_r < count_r) begin
          raddr     = lb_r[ADDR_W-1:0];
          state_nxt = ST_ADVCHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADVCHK: begin
        if (rdata.event_code != idm_pkg::EV_NONE) begin
          lb_nxt    = lb_r + 1'b1;
          state_nxt = ST_ADV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      lb_r        <= '0;
      cc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lb_r        <= lb_nxt;
      cc_r        <= cc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_bound_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    lb_r <= count_r)
    else $error("lower bound above stack count");

  a_comment_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.last) |=> out_valid_r && out_word_r.last)
    else $error("first comment word not followed by its exit word");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !pop)
    else $error("queue popped during scan");

endmodule

>>> rtl/inline_delimiter_matcher.sv
// Inline delimiter matcher: delimiter-stack span matching for one text line.
//
// Input channel: drive in_word with start high; the word is taken at a rising
// edge where start is high and busy is low. A two-word queue sits between the
// classifier and the stack engine, so busy rises only when both slots hold.
// Result channel: each result word shows on out_word for exactly one cycle with
// out_valid high. The receiver cannot stall; every word must be taken as shown.
// An accepted word passes the queue register and then the result register; a
// token that scans the stack also spends an ST_SCAN step on each entry read.
// A comment gives its second word in the cycle after its first. The engine
// pops a new word only in ST_IDLE: a line start, a drop or a push with nothing
// to scan stays there, a comment goes through ST_COMMENT2, a scan through
// ST_SCAN; a match adds ST_PUSHC to push the closer and, when the opener sat
// at the lower bound, ST_ADV and ST_ADVCHK per entry the bound steps over,
// ending in either. One stack read per cycle (registered read port, separate write port).
// Configuration: APB register 0 (byte address 0) holds the comment type code.
// Write only while idle; pready is tied high.
// Reset (rst_n low, synchronous) empties the stack, clears the lower bound,
// the comment flag, the queue and the comment code.
module inline_delimiter_matcher #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  idm_pkg::in_word_t  in_word,
  // result channel
  output logic               out_valid,
  output idm_pkg::out_word_t out_word,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [idm_pkg::TYPE_W-1:0] comment_code_r;
  logic                       cfg_wr;
  logic                       pop;
  logic                       head_valid;
  idm_pkg::cmd_t              head;

  // register 0 sits at byte address 0; paddr[2] picks the word
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(comment_code_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comment_code_r <= '0;
    end else if (cfg_wr) begin
      comment_code_r <= pwdata[idm_pkg::TYPE_W-1:0];
    end
  end

  // front: accept, classify, queue
  idm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_word      (in_word),
    .comment_code (comment_code_r),
    .pop          (pop),
    .busy         (busy),
    .head_valid   (head_valid),
    .head         (head)
  );

  // back: scan the stack, push, mark and advance the bound
  idm_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

endmodule
